/* rtl/core/rgba_over_rgb565_blend_core_defines.svh */
// ----------------------------------------------------------------------------
// RGBA over RGB565 blend core - assertion macros
// Implication checks on the core clock, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_OVER_RGB565_BLEND_CORE_DEFINES_SVH
`define RGBA_OVER_RGB565_BLEND_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RGBB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbb assertion failed");
`define RGBB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbb assertion failed");
`else
`define RGBB_ASSERT_IMP(label, ante, cons)
`define RGBB_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* rtl/core/rgbb_pkg.sv */
// ----------------------------------------------------------------------------
// RGBA over RGB565 blend - package
// Payload structs, alpha constants, RGB565 pack and the result select code.
// ----------------------------------------------------------------------------
package rgbb_pkg;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 16;

    localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'hFF;
    localparam logic [CHAN_W-1:0] ZERO_ALPHA = 8'h00;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pix_t;

    typedef struct packed {
        chan_t src_red;
        chan_t src_green;
        chan_t src_blue;
        chan_t src_alpha;
        pix_t  dest_pixel;
        logic  last_in;
    } item_in_t;

    typedef struct packed {
        pix_t result_pixel;
        logic last_out;
    } item_out_t;

    typedef enum logic [1:0] {
        SEL_PACK,
        SEL_DEST,
        SEL_MIX
    } sel_t;

    typedef struct packed {
        sel_t sel;
        pix_t dest;
        pix_t packed_src;
        logic last;
    } side_t;

    function automatic pix_t pack565(chan_t r, chan_t g, chan_t b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

/* rtl/core/rgbb_cfg.sv */
// ----------------------------------------------------------------------------
// RGBA over RGB565 blend - configuration registers
// APB slave holding the blend enable bit.
// ----------------------------------------------------------------------------
module rgbb_cfg
    import rgbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        blend_enable
);

    logic blend_enable_reg;
    logic blend_enable_next;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_comb
    begin
        blend_enable_next = blend_enable_reg;
        if (wr_hit)
        begin
            blend_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_enable_reg <= 1'b1;
        end
        else
        begin
            blend_enable_reg <= blend_enable_next;
        end
    end

    assign blend_enable = blend_enable_reg;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, blend_enable_reg} : 32'd0;

endmodule

/* rtl/core/rgbb_lane.sv */
// ----------------------------------------------------------------------------
// RGBA over RGB565 blend - channel lane
// Three-stage d + a*(s-d)/255: difference, product, shift-add quotient.
// ----------------------------------------------------------------------------
module rgbb_lane
    import rgbb_pkg::*;
(
    input  logic  clk,
    input  chan_t s,
    input  chan_t d,
    input  chan_t a,
    output chan_t mix
);

    chan_t        d1_reg, d2_reg, d3_reg;
    logic         neg1_reg, neg2_reg, neg3_reg;
    chan_t        diff1_reg;
    chan_t        a1_reg;
    logic [15:0]  prod2_reg;
    chan_t        q3_reg;
    chan_t        diff_next;
    logic [15:0]  prod_next;
    logic [16:0]  recip_sum;

    always_comb
    begin
        diff_next = (s >= d) ? (s - d) : (d - s);
        prod_next = {8'd0, a1_reg} * {8'd0, diff1_reg};
        recip_sum = {1'b0, prod2_reg} + 17'd1 + {9'd0, prod2_reg[15:8]};
    end

    always_ff @(posedge clk)
    begin
        d1_reg    <= d;
        neg1_reg  <= (s < d);
        diff1_reg <= diff_next;
        a1_reg    <= a;
        d2_reg    <= d1_reg;
        neg2_reg  <= neg1_reg;
        prod2_reg <= prod_next;
        d3_reg    <= d2_reg;
        neg3_reg  <= neg2_reg;
        q3_reg    <= recip_sum[15:8];
    end

    assign mix = neg3_reg ? (d3_reg - q3_reg) : (d3_reg + q3_reg);

endmodule

/* rtl/core/rgba_over_rgb565_blend_core.sv */
// ----------------------------------------------------------------------------
// RGBA over RGB565 blend core - top level
// Composites one RGBA8888 source pixel over an RGB565 destination pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on src and raise start; the transfer happens at each
//   rising edge with start high and busy low. busy stays low, so one pixel
//   may enter every clock.
//   Each result appears on result for exactly one cycle with done high.
//   Results leave in input order. Throughput is one pixel per clock; the
//   path holds four register stages: difference, 8x8 product, shift-add
//   divide by 255, select/pack.
//   blend_enable (APB, address 0, reset 1) selects compositing or plain
//   RGB565 packing; write it only while no pixel is in flight.
//   Reset clears all valid bits and sets blend_enable back to 1; pixels in
//   flight are dropped. The receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
`include "rgba_over_rgb565_blend_core_defines.svh"

module rgba_over_rgb565_blend_core
    import rgbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_in_t    src,
    output logic        done,
    output item_out_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      blend_enable;
    logic      accept;
    sel_t      sel_next;
    side_t     side_next;
    side_t     side_reg [3];
    logic      valid_reg [3];
    logic      done_reg;
    item_out_t result_reg;
    item_out_t result_next;
    chan_t     mix_r, mix_g, mix_b;

    rgbb_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .blend_enable (blend_enable)
    );

    rgbb_lane u_lane_r (
        .clk (clk),
        .s   (src.src_red),
        .d   ({src.dest_pixel[15:11], 3'b000}),
        .a   (src.src_alpha),
        .mix (mix_r)
    );

    rgbb_lane u_lane_g (
        .clk (clk),
        .s   (src.src_green),
        .d   ({src.dest_pixel[10:5], 2'b00}),
        .a   (src.src_alpha),
        .mix (mix_g)
    );

    rgbb_lane u_lane_b (
        .clk (clk),
        .s   (src.src_blue),
        .d   ({src.dest_pixel[4:0], 3'b000}),
        .a   (src.src_alpha),
        .mix (mix_b)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        priority if (!blend_enable || src.src_alpha == FULL_ALPHA)
        begin
            sel_next = SEL_PACK;
        end
        else if (src.src_alpha == ZERO_ALPHA)
        begin
            sel_next = SEL_DEST;
        end
        else
        begin
            sel_next = SEL_MIX;
        end
        side_next.sel        = sel_next;
        side_next.dest       = src.dest_pixel;
        side_next.packed_src = pack565(src.src_red, src.src_green, src.src_blue);
        side_next.last       = src.last_in;
    end

    always_comb
    begin
        result_next.last_out = side_reg[2].last;
        unique case (side_reg[2].sel)
            SEL_PACK: result_next.result_pixel = side_reg[2].packed_src;
            SEL_DEST: result_next.result_pixel = side_reg[2].dest;
            SEL_MIX:  result_next.result_pixel = pack565(mix_r, mix_g, mix_b);
            default:  result_next.result_pixel = side_reg[2].dest;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
            valid_reg[2] <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            valid_reg[1] <= valid_reg[0];
            valid_reg[2] <= valid_reg[1];
            done_reg     <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        side_reg[1] <= side_reg[0];
        side_reg[2] <= side_reg[1];
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RGBB_ASSERT_IMP(a_done_follows_accept, done, $past(accept, 4))
    `RGBB_ASSERT_IMP(a_last_tracks, done, result.last_out == $past(src.last_in, 4))
    `RGBB_ASSERT_IMP(a_clear_keeps_dest,
        done && $past(blend_enable && src.src_alpha == ZERO_ALPHA, 4),
        result.result_pixel == $past(src.dest_pixel, 4))

endmodule
